// ===== hdl/hbts_pkg.sv =====
package hbts_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_SUPPLY = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CS0_BASE    = 4'd0,
    REG_CS1_BASE    = 4'd1,
    REG_SPLIT_MASK  = 4'd2,
    REG_MAX_BURST   = 4'd3,
    REG_TWO_D_EN    = 4'd4,
    REG_LINE_BYTES  = 4'd5,
    REG_LINE_STRIDE = 4'd6,
    REG_IRQ_EN      = 4'd7
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_DELAY  = 6'b000010,
    PH_CS     = 6'b000100,
    PH_CA     = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CS_OFF = 6'b100000
  } phase_e;

  localparam logic [2:0] CA_BYTES   = 3'd6;
  localparam logic [2:0] WR_MAX     = 3'd4;

  typedef struct packed {
    logic [31:0] cs0_base;
    logic [31:0] cs1_base;
    logic [1:0]  burst_split_mask;
    logic [15:0] max_burst_bytes;
    logic        two_d_enable;
    logic [15:0] line_bytes;
    logic [31:0] line_stride;
    logic        irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] start_address;
    logic [19:0] total_bytes;
    logic        is_read;
    logic        register_space;
    logic [31:0] data_word;
    logic [19:0] chunk_bytes;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       cs_change;
    logic       cs_index;
    logic       cs_level;
    logic       chunk_done;
    logic       need_chunk;
    logic       done_irq;
    logic       accepted;
  } out_item_t;

endpackage

// ===== hdl/hbts_ifs.sv =====
interface hbts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] start_address;
  logic [19:0] total_bytes;
  logic        is_read;
  logic        register_space;
  logic [31:0] data_word;
  logic [19:0] chunk_bytes;

  modport source (output valid, mode, start_address, total_bytes, is_read,
                  register_space, data_word, chunk_bytes, input ready);
  modport sink   (input valid, mode, start_address, total_bytes, is_read,
                  register_space, data_word, chunk_bytes, output ready);
endinterface

interface hbts_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic       cs_change;
  logic       cs_index;
  logic       cs_level;
  logic       chunk_done;
  logic       need_chunk;
  logic       done_irq;
  logic       accepted;

  modport source (output valid, byte_valid, byte_value, cs_change, cs_index, cs_level,
                  chunk_done, need_chunk, done_irq, accepted, input ready);
  modport sink   (input valid, byte_valid, byte_value, cs_change, cs_index, cs_level,
                  chunk_done, need_chunk, done_irq, accepted, output ready);
endinterface

interface hbts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hbts_pkg::CFG_IDX_W-1:0] reg_idx;
  logic [31:0]                    wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ===== hdl/hbts_cfg_regs.sv =====
module hbts_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  hbts_cfg_if.sink      cfg_ch,
  output hbts_pkg::cfg_t cfg
);

  hbts_pkg::cfg_t cfg_r;
  hbts_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_idx)
        hbts_pkg::REG_CS0_BASE:    cfg_nxt.cs0_base         = cfg_ch.wdata;
        hbts_pkg::REG_CS1_BASE:    cfg_nxt.cs1_base         = cfg_ch.wdata;
        hbts_pkg::REG_SPLIT_MASK:  cfg_nxt.burst_split_mask = cfg_ch.wdata[1:0];
        hbts_pkg::REG_MAX_BURST:   cfg_nxt.max_burst_bytes  = cfg_ch.wdata[15:0];
        hbts_pkg::REG_TWO_D_EN:    cfg_nxt.two_d_enable     = cfg_ch.wdata[0];
        hbts_pkg::REG_LINE_BYTES:  cfg_nxt.line_bytes       = cfg_ch.wdata[15:0];
        hbts_pkg::REG_LINE_STRIDE: cfg_nxt.line_stride      = cfg_ch.wdata;
        hbts_pkg::REG_IRQ_EN:      cfg_nxt.irq_enable       = cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/hbts_cs_map.sv =====
module hbts_cs_map (
  input  logic [31:0] addr,
  input  logic [31:0] cs0_base,
  input  logic [31:0] cs1_base,
  output logic        cs,
  output logic [31:0] loc_addr
);

  logic        order_up;
  logic [31:0] hi_base;
  logic        above;

  // the higher base owns everything at or above it
  assign order_up = (cs1_base >= cs0_base);
  assign hi_base  = order_up ? cs1_base : cs0_base;
  assign above    = (addr >= hi_base);

  assign cs       = order_up ? above : ~above;
  assign loc_addr = above ? (addr - hi_base) : addr;

endmodule

// ===== hdl/hbts_seq_core.sv =====
module hbts_seq_core #(
  parameter int unsigned DELAY_TICKS = 72
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  hbts_pkg::in_item_t  item,
  input  hbts_pkg::cfg_t      cfg,
  output hbts_pkg::out_item_t res
);

  localparam logic [6:0] DELAY_LOAD = 7'(DELAY_TICKS);

  hbts_pkg::phase_e phase_r, phase_nxt;
  logic [6:0]  delay_r, delay_nxt;
  logic [2:0]  ca_left_r, ca_left_nxt;
  logic [47:0] cmd_r, cmd_nxt;
  logic [31:0] chunk_word_r, chunk_word_nxt;
  logic [19:0] chunk_left_r, chunk_left_nxt;
  logic [19:0] xfer_left_r, xfer_left_nxt;
  logic [15:0] line_left_r, line_left_nxt;
  logic [31:0] line_start_r, line_start_nxt;
  logic [15:0] burst_left_r, burst_left_nxt;
  logic [31:0] cur_addr_r, cur_addr_nxt;
  logic        read_dir_r, read_dir_nxt;
  logic        space_r, space_nxt;

  logic        start_ok;
  logic [31:0] map_addr;
  logic        cs_cur;
  logic [31:0] loc_cur;
  logic [2:0]  ca_dec;
  logic [7:0]  ca_byte;
  logic [19:0] xfer_dec;
  logic [15:0] line_dec, burst_dec;
  logic        line_end;

  // a taken start reports the select of its own address
  assign start_ok = (item.mode == hbts_pkg::MODE_START) &&
                    (phase_r == hbts_pkg::PH_IDLE) && (xfer_left_r == '0);
  assign map_addr = start_ok ? item.start_address : cur_addr_r;

  hbts_cs_map u_map_cur (
    .addr     (map_addr),
    .cs0_base (cfg.cs0_base),
    .cs1_base (cfg.cs1_base),
    .cs       (cs_cur),
    .loc_addr (loc_cur)
  );

  assign ca_dec    = ca_left_r - 3'd1;
  assign xfer_dec  = xfer_left_r - 20'd1;
  assign line_dec  = line_left_r - 16'd1;
  assign burst_dec = burst_left_r - 16'd1;
  assign line_end  = (line_left_r != '0) && (line_dec == '0);

  always_comb begin
    case (ca_dec)
      3'd5:    ca_byte = cmd_r[47:40];
      3'd4:    ca_byte = cmd_r[39:32];
      3'd3:    ca_byte = cmd_r[31:24];
      3'd2:    ca_byte = cmd_r[23:16];
      3'd1:    ca_byte = cmd_r[15:8];
      3'd0:    ca_byte = cmd_r[7:0];
      default: ca_byte = '0;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    delay_nxt      = delay_r;
    ca_left_nxt    = ca_left_r;
    cmd_nxt        = cmd_r;
    chunk_word_nxt = chunk_word_r;
    chunk_left_nxt = chunk_left_r;
    xfer_left_nxt  = xfer_left_r;
    line_left_nxt  = line_left_r;
    line_start_nxt = line_start_r;
    burst_left_nxt = burst_left_r;
    cur_addr_nxt   = cur_addr_r;
    read_dir_nxt   = read_dir_r;
    space_nxt      = space_r;
    res            = '0;
    res.cs_index   = cs_cur;

    case (item.mode)
      hbts_pkg::MODE_START: begin
        if (start_ok) begin
          res.accepted   = 1'b1;
          cur_addr_nxt   = item.start_address;
          line_start_nxt = item.start_address;
          xfer_left_nxt  = item.total_bytes;
          read_dir_nxt   = item.is_read;
          space_nxt      = item.register_space;
          line_left_nxt  = cfg.two_d_enable ? cfg.line_bytes : '0;
          chunk_left_nxt = '0;
          chunk_word_nxt = '0;
        end
      end
      hbts_pkg::MODE_SUPPLY: begin
        if (chunk_left_r == '0 && xfer_left_r != '0 && item.chunk_bytes != '0) begin
          res.accepted = 1'b1;
          if (read_dir_r) begin
            chunk_word_nxt = '0;
            chunk_left_nxt = item.chunk_bytes;
          end else begin
            chunk_word_nxt = item.data_word;
            chunk_left_nxt = (item.chunk_bytes > 20'(hbts_pkg::WR_MAX)) ?
                             20'(hbts_pkg::WR_MAX) : item.chunk_bytes;
          end
        end
      end
      hbts_pkg::MODE_TICK: begin
        unique case (phase_r)
          hbts_pkg::PH_IDLE: begin
            if (chunk_left_r != '0 && xfer_left_r != '0) begin
              phase_nxt      = hbts_pkg::PH_DELAY;
              delay_nxt      = DELAY_LOAD;
              ca_left_nxt    = hbts_pkg::CA_BYTES;
              cmd_nxt        = {read_dir_r, space_r, 1'b0, loc_cur[31:3], 13'd0, loc_cur[2:0]};
              burst_left_nxt = cfg.burst_split_mask[cs_cur] ? cfg.max_burst_bytes : '0;
            end
          end
          hbts_pkg::PH_DELAY: begin
            if (delay_r <= 7'd1) begin
              delay_nxt = '0;
              phase_nxt = hbts_pkg::PH_CS;
            end else begin
              delay_nxt = delay_r - 7'd1;
            end
          end
          hbts_pkg::PH_CS: begin
            phase_nxt     = hbts_pkg::PH_CA;
            res.cs_change = 1'b1;
            res.cs_level  = 1'b1;
          end
          hbts_pkg::PH_CA: begin
            if (ca_left_r == '0 || ca_left_r > hbts_pkg::CA_BYTES) begin
              ca_left_nxt = '0;
              phase_nxt   = hbts_pkg::PH_DATA;
            end else begin
              ca_left_nxt    = ca_dec;
              res.byte_valid = 1'b1;
              res.byte_value = ca_byte;
              if (ca_dec == '0) begin
                phase_nxt = hbts_pkg::PH_DATA;
              end
            end
          end
          hbts_pkg::PH_DATA: begin
            if (chunk_left_r != '0) begin
              if (xfer_left_r == '0) begin
                chunk_left_nxt = '0;
                phase_nxt      = hbts_pkg::PH_CS_OFF;
              end else begin
                res.byte_valid = 1'b1;
                res.byte_value = chunk_word_r[7:0];
                chunk_word_nxt = {8'd0, chunk_word_r[31:8]};
                chunk_left_nxt = chunk_left_r - 20'd1;
                xfer_left_nxt  = xfer_dec;
                if (xfer_dec == '0) begin
                  chunk_left_nxt = '0;
                  phase_nxt      = hbts_pkg::PH_CS_OFF;
                end else if (line_end) begin
                  // line end wins over a burst boundary in the same byte
                  cur_addr_nxt   = line_start_r + cfg.line_stride;
                  line_start_nxt = line_start_r + cfg.line_stride;
                  line_left_nxt  = cfg.line_bytes;
                  phase_nxt      = hbts_pkg::PH_CS_OFF;
                end else begin
                  if (line_left_r != '0) begin
                    line_left_nxt = line_dec;
                  end
                  if (burst_left_r != '0) begin
                    burst_left_nxt = burst_dec;
                    if (burst_dec == '0) begin
                      cur_addr_nxt   = cur_addr_r + 32'(cfg.max_burst_bytes);
                      burst_left_nxt = cfg.max_burst_bytes;
                      phase_nxt      = hbts_pkg::PH_CS_OFF;
                    end
                  end
                end
              end
              res.chunk_done = (chunk_left_nxt == '0);
            end
          end
          hbts_pkg::PH_CS_OFF: begin
            phase_nxt     = hbts_pkg::PH_IDLE;
            res.cs_change = 1'b1;
            res.done_irq  = (xfer_left_r == '0) && cfg.irq_enable;
          end
          default: phase_nxt = hbts_pkg::PH_IDLE;
        endcase
      end
      default: ;
    endcase

    res.need_chunk = (chunk_left_nxt == '0) && (xfer_left_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hbts_pkg::PH_IDLE;
      delay_r      <= '0;
      ca_left_r    <= '0;
      cmd_r        <= '0;
      chunk_word_r <= '0;
      chunk_left_r <= '0;
      xfer_left_r  <= '0;
      line_left_r  <= '0;
      line_start_r <= '0;
      burst_left_r <= '0;
      cur_addr_r   <= '0;
      read_dir_r   <= 1'b0;
      space_r      <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      delay_r      <= delay_nxt;
      ca_left_r    <= ca_left_nxt;
      cmd_r        <= cmd_nxt;
      chunk_word_r <= chunk_word_nxt;
      chunk_left_r <= chunk_left_nxt;
      xfer_left_r  <= xfer_left_nxt;
      line_left_r  <= line_left_nxt;
      line_start_r <= line_start_nxt;
      burst_left_r <= burst_left_nxt;
      cur_addr_r   <= cur_addr_nxt;
      read_dir_r   <= read_dir_nxt;
      space_r      <= space_nxt;
    end
  end

endmodule

// ===== hdl/hyperbus_transfer_sequencer.sv =====
// Channel  | Dir | Handshake     | Carries
// in_ch    | in  | valid/ready   | mode, start/supply/tick request fields
// out_ch   | out | valid/ready   | one bus step result per request
// cfg_ch   | in  | valid/ready   | reg_idx, wdata (register write)
//
// Each request passes through the input register, then through the sequencer
// logic into the result register; 1 per cycle while out_ch is not stalled.
// The state update of one request is registered in the core and feeds the next.
// rst_n is synchronous; it clears valid flags, config, counters and the bus phase.
// A stalled result holds the pipe; in_ch.ready stays high while the input
// register is empty or drains into the result register this cycle.
module hyperbus_transfer_sequencer #(
  parameter int unsigned DELAY_TICKS = 72
) (
  input  logic       clk,
  input  logic       rst_n,
  hbts_in_if.sink    in_ch,
  hbts_out_if.source out_ch,
  hbts_cfg_if.sink   cfg_ch
);

  hbts_pkg::cfg_t      cfg;
  hbts_pkg::in_item_t  in_r;
  logic                in_vld_r;
  hbts_pkg::out_item_t out_r;
  hbts_pkg::out_item_t res;
  logic                out_vld_r;
  logic                process;
  logic                in_fire;

  hbts_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  hbts_seq_core #(
    .DELAY_TICKS (DELAY_TICKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (process),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign process     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || process;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (process) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r.mode           <= in_ch.mode;
      in_r.start_address  <= in_ch.start_address;
      in_r.total_bytes    <= in_ch.total_bytes;
      in_r.is_read        <= in_ch.is_read;
      in_r.register_space <= in_ch.register_space;
      in_r.data_word      <= in_ch.data_word;
      in_r.chunk_bytes    <= in_ch.chunk_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (process) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.byte_valid = out_r.byte_valid;
  assign out_ch.byte_value = out_r.byte_value;
  assign out_ch.cs_change  = out_r.cs_change;
  assign out_ch.cs_index   = out_r.cs_index;
  assign out_ch.cs_level   = out_r.cs_level;
  assign out_ch.chunk_done = out_r.chunk_done;
  assign out_ch.need_chunk = out_r.need_chunk;
  assign out_ch.done_irq   = out_r.done_irq;
  assign out_ch.accepted   = out_r.accepted;

  a_process_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> out_vld_r)
    else $error("processed request did not reach result register");

  a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !process) |=> in_vld_r)
    else $error("stalled request dropped from input register");

  a_irq_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.done_irq) |-> (out_r.cs_change && !out_r.cs_level))
    else $error("done_irq without chip select release");

  a_accept_no_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.accepted) |-> (!out_r.byte_valid && !out_r.cs_change))
    else $error("accepted request also drove the bus");

endmodule

// ===== test/hyperbus_transfer_sequencer_tb.sv =====
module hyperbus_transfer_sequencer_tb;

  localparam int unsigned SEQ_DELAY    = 72;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  // Tracks the bus sequencer state and queues the step each request should produce.
  class bus_step_tracker;
    hbts_pkg::cfg_t      regs;
    hbts_pkg::phase_e    bus_phase;
    logic [6:0]          delay_left;
    logic [6:0]          delay_reload;
    logic [2:0]          ca_left;
    logic [47:0]         cmd_word;
    logic [31:0]         chunk_word;
    logic [19:0]         chunk_left;
    logic [19:0]         xfer_left;
    logic [15:0]         line_left;
    logic [15:0]         burst_left;
    logic [31:0]         line_start;
    logic [31:0]         cur_addr;
    logic                rd_dir;
    logic                space;
    hbts_pkg::out_item_t expected_steps[$];
    int unsigned         errors;
    int unsigned         results_checked;
    int unsigned         bursts_opened;
    int unsigned         irqs_seen;

    function new(int unsigned delay);
      regs = '0;
      bus_phase = hbts_pkg::PH_IDLE;
      delay_left = '0;
      delay_reload = 7'(delay);
      ca_left = '0;
      cmd_word = '0;
      chunk_word = '0;
      chunk_left = '0;
      xfer_left = '0;
      line_left = '0;
      burst_left = '0;
      line_start = '0;
      cur_addr = '0;
      rd_dir = 1'b0;
      space = 1'b0;
    endfunction

    function void set_register(hbts_pkg::cfg_reg_e idx, logic [31:0] v);
      case (idx)
        hbts_pkg::REG_CS0_BASE:    regs.cs0_base = v;
        hbts_pkg::REG_CS1_BASE:    regs.cs1_base = v;
        hbts_pkg::REG_SPLIT_MASK:  regs.burst_split_mask = v[1:0];
        hbts_pkg::REG_MAX_BURST:   regs.max_burst_bytes = v[15:0];
        hbts_pkg::REG_TWO_D_EN:    regs.two_d_enable = v[0];
        hbts_pkg::REG_LINE_BYTES:  regs.line_bytes = v[15:0];
        hbts_pkg::REG_LINE_STRIDE: regs.line_stride = v;
        hbts_pkg::REG_IRQ_EN:      regs.irq_enable = v[0];
        default: ;
      endcase
    endfunction

    // The higher base owns everything at or above it; the other select gets the rest.
    function logic select_chip(logic [31:0] addr, output logic [31:0] offs);
      offs = addr;
      if (regs.cs1_base >= regs.cs0_base) begin
        if (addr >= regs.cs1_base) begin
          offs = addr - regs.cs1_base;
          return 1'b1;
        end
        return 1'b0;
      end
      if (addr >= regs.cs0_base) begin
        offs = addr - regs.cs0_base;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function hbts_pkg::out_item_t advance_sequencer(hbts_pkg::in_item_t it);
      hbts_pkg::out_item_t r;
      logic [31:0]         offs;
      logic [19:0]         n;
      logic [47:0]         shifted;
      logic                cs;
      r = '0;
      cs = select_chip(cur_addr, offs);
      case (it.mode)
        hbts_pkg::MODE_START: begin
          if (bus_phase == hbts_pkg::PH_IDLE && xfer_left == '0) begin
            r.accepted = 1'b1;
            cur_addr = it.start_address;
            line_start = cur_addr;
            xfer_left = it.total_bytes;
            rd_dir = it.is_read;
            space = it.register_space;
            line_left = regs.two_d_enable ? regs.line_bytes : 16'd0;
            chunk_left = '0;
            chunk_word = '0;
            cs = select_chip(cur_addr, offs);
          end
        end
        hbts_pkg::MODE_SUPPLY: begin
          n = it.chunk_bytes;
          if (chunk_left == '0 && xfer_left != '0 && n != '0) begin
            r.accepted = 1'b1;
            if (rd_dir) begin
              chunk_word = '0;
            end else begin
              chunk_word = it.data_word;
              if (n > 20'(hbts_pkg::WR_MAX)) n = 20'(hbts_pkg::WR_MAX);
            end
            chunk_left = n;
          end
        end
        hbts_pkg::MODE_TICK: begin
          case (bus_phase)
            hbts_pkg::PH_IDLE: begin
              if (chunk_left != '0 && xfer_left != '0) begin
                bus_phase = hbts_pkg::PH_DELAY;
                delay_left = delay_reload;
                ca_left = hbts_pkg::CA_BYTES;
                cmd_word = {rd_dir, space, 1'b0, offs[31:3], 13'd0, offs[2:0]};
                burst_left = regs.burst_split_mask[cs] ? regs.max_burst_bytes : 16'd0;
              end
            end
            hbts_pkg::PH_DELAY: begin
              if (delay_left <= 7'd1) begin
                delay_left = '0;
                bus_phase = hbts_pkg::PH_CS;
              end else begin
                delay_left = delay_left - 7'd1;
              end
            end
            hbts_pkg::PH_CS: begin
              bus_phase = hbts_pkg::PH_CA;
              r.cs_change = 1'b1;
              r.cs_level = 1'b1;
            end
            hbts_pkg::PH_CA: begin
              if (ca_left == '0 || ca_left > hbts_pkg::CA_BYTES) begin
                ca_left = '0;
                bus_phase = hbts_pkg::PH_DATA;
              end else begin
                ca_left = ca_left - 3'd1;
                shifted = cmd_word >> (8 * ca_left);
                r.byte_valid = 1'b1;
                r.byte_value = shifted[7:0];
                if (ca_left == '0) bus_phase = hbts_pkg::PH_DATA;
              end
            end
            hbts_pkg::PH_DATA: begin
              // no chunk: the bus just waits
              if (chunk_left != '0) begin
                if (xfer_left == '0) begin
                  chunk_left = '0;
                  r.chunk_done = 1'b1;
                  bus_phase = hbts_pkg::PH_CS_OFF;
                end else begin
                  r.byte_valid = 1'b1;
                  r.byte_value = chunk_word[7:0];
                  chunk_word = chunk_word >> 8;
                  chunk_left = chunk_left - 20'd1;
                  xfer_left = xfer_left - 20'd1;
                  if (xfer_left == '0) begin
                    chunk_left = '0;
                    bus_phase = hbts_pkg::PH_CS_OFF;
                  end else begin
                    if (line_left != '0) begin
                      line_left = line_left - 16'd1;
                      if (line_left == '0) begin
                        cur_addr = line_start + regs.line_stride;
                        line_start = cur_addr;
                        line_left = regs.line_bytes;
                        bus_phase = hbts_pkg::PH_CS_OFF;
                      end
                    end
                    // line end wins over burst end on the same byte
                    if (bus_phase != hbts_pkg::PH_CS_OFF && burst_left != '0) begin
                      burst_left = burst_left - 16'd1;
                      if (burst_left == '0) begin
                        cur_addr = cur_addr + 32'(regs.max_burst_bytes);
                        burst_left = regs.max_burst_bytes;
                        bus_phase = hbts_pkg::PH_CS_OFF;
                      end
                    end
                  end
                  if (chunk_left == '0) r.chunk_done = 1'b1;
                end
              end
            end
            hbts_pkg::PH_CS_OFF: begin
              bus_phase = hbts_pkg::PH_IDLE;
              r.cs_change = 1'b1;
              if (xfer_left == '0 && regs.irq_enable) r.done_irq = 1'b1;
            end
            default: bus_phase = hbts_pkg::PH_IDLE;
          endcase
        end
        default: ;
      endcase
      r.cs_index = cs;
      r.need_chunk = (chunk_left == '0 && xfer_left != '0);
      return r;
    endfunction

    // Returns 1 for an accepted start or supply, or for a tick outside the delay phase.
    function bit note_request(hbts_pkg::in_item_t it);
      hbts_pkg::out_item_t want;
      bit                  worked;
      worked = (it.mode == hbts_pkg::MODE_TICK) && (bus_phase != hbts_pkg::PH_DELAY);
      want = advance_sequencer(it);
      if (want.accepted) worked = 1'b1;
      if (want.cs_change && want.cs_level) bursts_opened++;
      if (want.done_irq) irqs_seen++;
      expected_steps.push_back(want);
      return worked;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("MISMATCH %s", what);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_checked, name, got, want));
    endtask

    task check_step(hbts_pkg::out_item_t got);
      hbts_pkg::out_item_t want;
      results_checked++;
      if (expected_steps.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no request pending",
                                results_checked));
        return;
      end
      want = expected_steps.pop_front();
      compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
      compare_field("byte_value", got.byte_value, want.byte_value);
      compare_field("cs_change", 8'(got.cs_change), 8'(want.cs_change));
      compare_field("cs_index", 8'(got.cs_index), 8'(want.cs_index));
      compare_field("cs_level", 8'(got.cs_level), 8'(want.cs_level));
      compare_field("chunk_done", 8'(got.chunk_done), 8'(want.chunk_done));
      compare_field("need_chunk", 8'(got.need_chunk), 8'(want.need_chunk));
      compare_field("done_irq", 8'(got.done_irq), 8'(want.done_irq));
      compare_field("accepted", 8'(got.accepted), 8'(want.accepted));
    endtask

    function int unsigned outstanding();
      return expected_steps.size();
    endfunction

    function bit wants_chunk();
      return chunk_left == '0 && xfer_left != '0;
    endfunction

    function bit at_rest();
      return bus_phase == hbts_pkg::PH_IDLE && xfer_left == '0;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hbts_in_if  in_ch();
  hbts_out_if out_ch();
  hbts_cfg_if cfg_ch();

  hyperbus_transfer_sequencer #(
    .DELAY_TICKS(SEQ_DELAY)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  bus_step_tracker tracker;
  hbts_pkg::cfg_t  cur_cfg;
  int unsigned     gap_odds;
  int unsigned     stall_odds;
  int unsigned     stall_left;
  int unsigned     sent_count;
  int unsigned     work_count;
  int unsigned     settings_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin : result_side
    hbts_pkg::out_item_t got;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.byte_valid = out_ch.byte_valid;
      got.byte_value = out_ch.byte_value;
      got.cs_change  = out_ch.cs_change;
      got.cs_index   = out_ch.cs_index;
      got.cs_level   = out_ch.cs_level;
      got.chunk_done = out_ch.chunk_done;
      got.need_chunk = out_ch.need_chunk;
      got.done_irq   = out_ch.done_irq;
      got.accepted   = out_ch.accepted;
      tracker.check_step(got);
    end
    if (stall_odds != 0 && stall_left == 0 && $urandom_range(1, stall_odds) == 1)
      stall_left = $urandom_range(1, 11);
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic hbts_pkg::in_item_t noise_item();
    hbts_pkg::in_item_t it;
    it.mode           = 2'($urandom_range(0, 3));
    it.start_address  = $urandom;
    it.total_bytes    = 20'($urandom);
    it.is_read        = 1'($urandom_range(0, 1));
    it.register_space = 1'($urandom_range(0, 1));
    it.data_word      = $urandom;
    it.chunk_bytes    = 20'($urandom);
    return it;
  endfunction

  task automatic send_request(hbts_pkg::in_item_t it);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= it.mode;
    in_ch.start_address  <= it.start_address;
    in_ch.total_bytes    <= it.total_bytes;
    in_ch.is_read        <= it.is_read;
    in_ch.register_space <= it.register_space;
    in_ch.data_word      <= it.data_word;
    in_ch.chunk_bytes    <= it.chunk_bytes;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_count++;
    if (tracker.note_request(it)) work_count++;
  endtask

  task automatic req_start(logic [31:0] addr, logic [19:0] len, logic rd, logic regsp);
    hbts_pkg::in_item_t it;
    it = noise_item();
    it.mode = hbts_pkg::MODE_START;
    it.start_address = addr;
    it.total_bytes = len;
    it.is_read = rd;
    it.register_space = regsp;
    send_request(it);
  endtask

  task automatic req_supply(logic [31:0] word, logic [19:0] len);
    hbts_pkg::in_item_t it;
    it = noise_item();
    it.mode = hbts_pkg::MODE_SUPPLY;
    it.data_word = word;
    it.chunk_bytes = len;
    send_request(it);
  endtask

  task automatic req_tick();
    hbts_pkg::in_item_t it;
    it = noise_item();
    it.mode = hbts_pkg::MODE_TICK;
    send_request(it);
  endtask

  task automatic put_reg(hbts_pkg::cfg_reg_e idx, logic [31:0] v);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata   <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    tracker.set_register(idx, v);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_settings(hbts_pkg::cfg_t s);
    logic [31:0] junk;
    junk = $urandom;
    cur_cfg = s;
    put_reg(hbts_pkg::REG_CS0_BASE, s.cs0_base);
    put_reg(hbts_pkg::REG_CS1_BASE, s.cs1_base);
    put_reg(hbts_pkg::REG_SPLIT_MASK, {junk[31:2], s.burst_split_mask});
    put_reg(hbts_pkg::REG_MAX_BURST, {junk[15:0], s.max_burst_bytes});
    put_reg(hbts_pkg::REG_TWO_D_EN, {junk[31:1], s.two_d_enable});
    put_reg(hbts_pkg::REG_LINE_BYTES, {junk[31:16], s.line_bytes});
    put_reg(hbts_pkg::REG_LINE_STRIDE, s.line_stride);
    put_reg(hbts_pkg::REG_IRQ_EN, {junk[30:0], s.irq_enable});
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  task automatic settle();
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (tracker.outstanding() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic hbts_pkg::cfg_t settings_for(int unsigned p);
    hbts_pkg::cfg_t s;
    case (p)
      0: s = '{cs0_base: 32'h0, cs1_base: 32'h0000_1000, burst_split_mask: 2'b01,
               max_burst_bytes: 16'd3, two_d_enable: 1'b0, line_bytes: 16'd0,
               line_stride: 32'h0, irq_enable: 1'b1};
      1: s = '{cs0_base: 32'hFFFF_FFFF, cs1_base: 32'h0, burst_split_mask: 2'b11,
               max_burst_bytes: 16'd1, two_d_enable: 1'b1, line_bytes: 16'd2,
               line_stride: 32'hFFFF_FFFF, irq_enable: 1'b0};
      2: s = '{cs0_base: 32'h0, cs1_base: 32'hFFFF_FFFF, burst_split_mask: 2'b10,
               max_burst_bytes: 16'hFFFF, two_d_enable: 1'b1, line_bytes: 16'd1,
               line_stride: 32'h0, irq_enable: 1'b1};
      default: begin
        s.cs0_base = $urandom;
        s.cs1_base = $urandom_range(0, 1) ? $urandom
                                          : s.cs0_base + 32'($urandom_range(0, 64));
        s.burst_split_mask = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       s.max_burst_bytes = 16'd0;
          1:       s.max_burst_bytes = 16'hFFFF;
          default: s.max_burst_bytes = 16'($urandom_range(1, 8));
        endcase
        s.two_d_enable = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       s.line_bytes = 16'd0;
          1:       s.line_bytes = 16'hFFFF;
          default: s.line_bytes = 16'($urandom_range(1, 10));
        endcase
        s.line_stride = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 64));
        s.irq_enable = 1'($urandom_range(0, 1));
      end
    endcase
    return s;
  endfunction

  // addresses cluster around the select boundaries
  function automatic logic [31:0] pick_address();
    logic [31:0] near;
    near = $urandom_range(0, 40);
    case ($urandom_range(0, 5))
      0:       return cur_cfg.cs0_base + near;
      1:       return cur_cfg.cs1_base + near;
      2:       return cur_cfg.cs1_base - 32'd1 - near;
      3:       return $urandom;
      4:       return near;
      default: return 32'hFFFF_FFFF - near;
    endcase
  endfunction

  // short transfers: every burst costs the full command delay
  function automatic logic [19:0] pick_length();
    case ($urandom_range(0, 15))
      0:       return 20'd0;
      1:       return 20'($urandom_range(7, 12));
      default: return 20'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [19:0] pick_chunk_len(logic rd);
    case ($urandom_range(0, 19))
      0:       return 20'd0;
      1:       return 20'($urandom);
      2:       return 20'($urandom_range(5, 8));
      default: return rd ? 20'($urandom_range(1, 6)) : 20'($urandom_range(1, 4));
    endcase
  endfunction

  // one start, then chunks and ticks until the bus is back at rest
  task automatic run_transfer();
    logic        rd;
    int unsigned r;
    rd = 1'($urandom_range(0, 1));
    req_start(pick_address(), pick_length(), rd, 1'($urandom_range(0, 1)));
    while (!tracker.at_rest()) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        send_request(noise_item());
      else if (tracker.wants_chunk() && r < 90)
        req_supply($urandom, pick_chunk_len(rd));
      else
        req_tick();
    end
  endtask

  initial begin
    hbts_pkg::in_item_t odd;
    int unsigned        goal;
    tracker = new(SEQ_DELAY);
    gap_odds = 5;
    stall_odds = 5;
    stall_left = 0;
    sent_count = 0;
    work_count = 0;
    settings_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = hbts_pkg::MODE_TICK;
    in_ch.start_address = '0;
    in_ch.total_bytes = '0;
    in_ch.is_read = 1'b0;
    in_ch.register_space = 1'b0;
    in_ch.data_word = '0;
    in_ch.chunk_bytes = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_idx = hbts_pkg::REG_CS0_BASE;
    cfg_ch.wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    program_settings('{cs0_base: 32'h0, cs1_base: 32'h0, burst_split_mask: 2'b00,
                       max_burst_bytes: 16'd0, two_d_enable: 1'b0, line_bytes: 16'd0,
                       line_stride: 32'h0, irq_enable: 1'b1});
    odd = noise_item();
    odd.mode = MODE_UNUSED;
    send_request(odd);
    req_supply(32'hFFFF_FFFF, 20'd1);              // nothing to feed yet
    req_start(32'hFFFF_FFFF, 20'd0, 1'b0, 1'b1);   // empty transfer
    req_tick();
    req_start(32'hFFFF_FFFF, 20'd5, 1'b0, 1'b1);
    req_start(32'h0, 20'hFFFFF, 1'b1, 1'b0);       // busy, dropped
    req_supply(32'h0, 20'd0);
    req_supply(32'hA5C3_0FF0, 20'hFFFFF);          // clipped to a word
    req_supply(32'h1234_5678, 20'd1);              // chunk still pending
    while (!tracker.wants_chunk()) req_tick();
    req_tick();                                    // data phase starved
    req_supply(32'h0000_017E, 20'd2);              // last byte drops the rest
    while (!tracker.at_rest()) req_tick();
    req_start(32'h0, 20'd3, 1'b1, 1'b0);
    req_supply(32'hFFFF_FFFF, 20'hFFFFF);          // read budget past the end
    while (!tracker.at_rest()) req_tick();

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      program_settings(settings_for(p));
      case (p % 3)
        0:       gap_odds = 3;
        1:       gap_odds = 0;
        default: gap_odds = 10;
      endcase
      if (p == PHASES - 1) gap_odds = 0;
      stall_odds = gap_odds;
      goal = sent_count + RANDOM_ITEMS / PHASES;
      while (sent_count < goal) run_transfer();
    end
    settle();

    if (tracker.outstanding() != 0)
      tracker.flag_mismatch($sformatf("%0d expected results never arrived",
                                      tracker.outstanding()));
    $display("Sent %0d requests (%0d did work) under %0d register settings.",
             sent_count, work_count, settings_count);
    $display("Checked %0d results: %0d bursts opened, %0d done interrupts.",
             tracker.results_checked, tracker.bursts_opened, tracker.irqs_seen);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("Some tests failed");
    $finish;
  end

endmodule
